@@ rtl/core/b36_pkg.sv @@
// Package for the base-36 text-to-integer parser.
// Holds the status codes, character constants, result struct and digit decode.
// No dependencies.
package b36_pkg;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_BAD   = 2'd2
    } t_status;

    localparam logic [7:0]  CH_END   = 8'h00;
    localparam logic [7:0]  CH_MINUS = 8'h2D;
    localparam logic [32:0] LIMIT    = 33'd2147483647;

    typedef struct packed {
        logic        ok;
        logic [5:0]  val;
    } t_digit;

    typedef struct packed {
        logic signed [31:0] value;
        t_status            status;
    } t_result;

    function automatic t_digit digit_of(input logic [7:0] ch);
        t_digit d;
        d.ok  = 1'b1;
        d.val = 6'd0;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            d.val = 6'(ch - 8'h30);
        end else if (ch >= 8'h41 && ch <= 8'h5A) begin
            d.val = 6'(ch - 8'h41 + 8'd10);
        end else if (ch >= 8'h61 && ch <= 8'h7A) begin
            d.val = 6'(ch - 8'h61 + 8'd10);
        end else begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage

@@ rtl/core/base36_text_to_int_parser_top.sv @@
// A terminator item is held in the input register, then in the result register, on its way out.
// Throughput: one item per cycle when not stalled; a non-terminator never waits on the output.
// A terminator stalls only while the output register still holds an untaken result.
// Reset (synchronous, active low) empties both registers and returns to the string start.
// Top level of the base-36 parser: input register, parse state, result register.
// Depends on b36_pkg and b36_accum.
module base36_text_to_int_parser_top #(
    parameter int MAX_DIGITS = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_char_code,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_value,
    output logic [1:0]         o_status
);
    import b36_pkg::*;

    logic        r_in_vld, n_in_vld;
    logic [7:0]  r_char,   n_char;
    logic        r_out_vld, n_out_vld;
    t_result     r_res,    n_res;
    t_result     acc_res;
    logic        is_end;
    logic        out_free;
    logic        consume;
    logic        accept;

    assign is_end   = (r_char == CH_END);
    assign out_free = !r_out_vld || !i_stall;
    assign consume  = r_in_vld && (!is_end || out_free);
    assign o_stall  = r_in_vld && !consume;
    assign accept   = i_valid && !o_stall;

    b36_accum #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (consume),
        .i_char   (r_char),
        .o_result (acc_res)
    );

    always_comb begin
        n_in_vld  = r_in_vld;
        n_char    = r_char;
        n_out_vld = r_out_vld;
        n_res     = r_res;
        if (consume) begin
            n_in_vld = 1'b0;
        end
        if (accept) begin
            n_in_vld = 1'b1;
            n_char   = i_char_code;
        end
        if (r_out_vld && !i_stall) begin
            n_out_vld = 1'b0;
        end
        if (consume && is_end) begin
            n_out_vld = 1'b1;
            n_res     = acc_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
        r_char <= n_char;
        r_res  <= n_res;
    end

    assign o_valid  = r_out_vld;
    assign o_value  = r_res.value;
    assign o_status = r_res.status;

endmodule

@@ rtl/core/b36_accum.sv @@
// Parse state for the base-36 parser: sign, Horner accumulator, digit count.
// Builds the result from the state when a terminator is consumed.
// Depends on b36_pkg.
module b36_accum #(
    parameter int MAX_DIGITS = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_char,
    output b36_pkg::t_result  o_result
);
    import b36_pkg::*;

    logic        r_at_start, n_at_start;
    logic        r_negative, n_negative;
    logic [32:0] r_mag,      n_mag;
    logic [2:0]  r_count,    n_count;
    logic        r_bad,      n_bad;
    t_digit      dig;
    logic [32:0] mag_x36;
    logic [31:0] mag_lo;

    assign dig     = digit_of(i_char);
    assign mag_x36 = (r_mag << 5) + (r_mag << 2);
    assign mag_lo  = r_mag[31:0];

    always_comb begin
        n_at_start = r_at_start;
        n_negative = r_negative;
        n_mag      = r_mag;
        n_count    = r_count;
        n_bad      = r_bad;
        if (i_step) begin
            if (i_char == CH_END) begin
                n_at_start = 1'b1;
                n_negative = 1'b0;
                n_mag      = 33'd0;
                n_count    = 3'd0;
                n_bad      = 1'b0;
            end else if (r_at_start && i_char == CH_MINUS) begin
                n_at_start = 1'b0;
                n_negative = 1'b1;
            end else begin
                n_at_start = 1'b0;
                // after a bad character keep scaling by place, add nothing
                if (r_count < 3'(MAX_DIGITS)) begin
                    n_mag = mag_x36 + ((dig.ok && !r_bad) ? {27'd0, dig.val} : 33'd0);
                    n_bad = r_bad | !dig.ok;
                end
                if (r_count != 3'd7) begin
                    n_count = r_count + 3'd1;
                end
            end
        end
    end

    always_comb begin
        o_result.value  = 32'sd0;
        o_result.status = ST_OK;
        if (r_at_start || r_count > 3'(MAX_DIGITS) || r_mag > LIMIT) begin
            o_result.status = ST_RANGE;
        end else if (r_bad) begin
            o_result.status = ST_BAD;
        end else begin
            o_result.value = r_negative ? $signed(32'd0 - mag_lo) : $signed(mag_lo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start <= 1'b1;
            r_negative <= 1'b0;
            r_mag      <= 33'd0;
            r_count    <= 3'd0;
            r_bad      <= 1'b0;
        end else begin
            r_at_start <= n_at_start;
            r_negative <= n_negative;
            r_mag      <= n_mag;
            r_count    <= n_count;
            r_bad      <= n_bad;
        end
    end

endmodule

@@ rtl/core/b36_checker.sv @@
// Port-level checks for the base-36 parser top level, attached by bind.
// Depends on b36_pkg.
module b36_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [31:0] o_value,
    input logic [1:0]         o_status
);
    import b36_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_value) && $stable(o_status))
        else $error("result item changed while stalled");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_RANGE || o_status == ST_BAD))
        else $error("undefined status code");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_value == 32'sd0)
        else $error("nonzero value with error status");

    a_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_OK |-> o_value != 32'sh80000000)
        else $error("value outside signed range");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind base36_text_to_int_parser_top b36_checker u_b36_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_value  (o_value),
    .o_status (o_status)
);
